// ----- rtl/per_account_low_watermark_table_macros.svh -----
// Assertion macros used by the low watermark table top level.
`ifndef PER_ACCOUNT_LOW_WATERMARK_TABLE_MACROS_SVH
`define PER_ACCOUNT_LOW_WATERMARK_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define PLWM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PLWM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PLWM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define PLWM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/plwm_pkg.sv -----
// Types and constants shared by the low watermark table.
package plwm_pkg;
   localparam int TYPES = 4;
   localparam logic [63:0] ALL_ONES = '1;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [TYPES-1:0] tracked;
      logic [63:0]      key;
   } meta_type;

   typedef struct packed {
      logic [63:0]            wmark;
      logic [TYPES-1:0][63:0] height;
   } row_type;
endpackage

// ----- rtl/plwm_meta_mem.sv -----
// Account directory memory: valid flag, tracked types and key per entry.
module plwm_meta_mem #(
   parameter int ACCOUNTS = 16,
   parameter int AW = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  plwm_pkg::meta_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output plwm_pkg::meta_type  rd_data
);
   plwm_pkg::meta_type mem [ACCOUNTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/plwm_row_mem.sv -----
// Height row memory: watermark and per-type heights per entry.
module plwm_row_mem #(
   parameter int ACCOUNTS = 16,
   parameter int AW = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  plwm_pkg::row_type  wr_data,
   input  logic [AW-1:0]      rd_addr,
   output plwm_pkg::row_type  rd_data
);
   plwm_pkg::row_type mem [ACCOUNTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/per_account_low_watermark_table.sv -----
// Top level of the per-account low watermark table.
//
//  Channel  Direction  Handshake              Word
//  req      in         req_valid / req_stall  cmd, account_key, type_mask, height_sel, new_height
//  rsp      out        rsp_valid / rsp_stall  status, low_mark, tracked_types
//
// A word is accepted only in the idle step; each then passes through a key search that reads
// the directory memory one entry per cycle, one row read, and the update, minimum and
// write-back steps, so no new word is taken before the last one is through. The response
// register loads in the write-back step. After reset a clearing pass empties the
// directory; no word is taken meanwhile. A word is taken while the previous response still
// waits; the block holds in its last step while rsp_stall keeps the response register full.
`include "per_account_low_watermark_table_macros.svh"
module per_account_low_watermark_table #(
   parameter int ACCOUNTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_account_key,
   input  logic [3:0]  req_type_mask,
   input  logic [1:0]  req_height_sel,
   input  logic [63:0] req_new_height,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_low_mark,
   output logic [3:0]  rsp_tracked_types
);
   localparam int AW = (ACCOUNTS > 1) ? $clog2(ACCOUNTS) : 1;
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] LAST = CW'(ACCOUNTS);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_ROW   = 7'b0001000,
      S_CALC  = 7'b0010000,
      S_MIN   = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic found_ff, found_in, free_ff, free_in;
   logic [AW-1:0] fidx_ff, fidx_in, eidx_ff, eidx_in;
   logic [3:0] trk_ff, trk_in, ntrk_ff, ntrk_in;
   logic raise_ff, raise_in, rowwr_ff, rowwr_in;
   logic [1:0] cmd_ff;
   logic [63:0] key_ff, nh_ff;
   logic [3:0] mask_ff;
   logic [1:0] ht_ff;
   plwm_pkg::row_type row_ff, row_in;
   logic [63:0] m01_ff, m23_ff, m01_in, m23_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic [63:0] minh_ff, minh_in;
   logic [3:0] otrk_ff, otrk_in;

   logic m_wr_en, r_wr_en;
   logic [AW-1:0] m_wr_addr, m_rd_addr;
   plwm_pkg::meta_type m_wr_data, m_rd_data;
   plwm_pkg::row_type r_wr_data, r_rd_data, fin_row;
   logic [63:0] mfin;
   logic ok, req_take, rsp_free;

   plwm_meta_mem #(.ACCOUNTS(ACCOUNTS), .AW(AW)) u_meta (
      .clock(clock), .wr_en(m_wr_en), .wr_addr(m_wr_addr), .wr_data(m_wr_data),
      .rd_addr(m_rd_addr), .rd_data(m_rd_data)
   );

   plwm_row_mem #(.ACCOUNTS(ACCOUNTS), .AW(AW)) u_row (
      .clock(clock), .wr_en(r_wr_en), .wr_addr(eidx_ff), .wr_data(r_wr_data),
      .rd_addr(eidx_ff), .rd_data(r_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign ok = found_ff || (cmd_ff == plwm_pkg::CMD_ADD && free_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_low_mark = minh_ff;
   assign rsp_tracked_types = otrk_ff;
   assign m_rd_addr = cnt_ff[AW-1:0];

   always_comb begin
      mfin = (m01_ff < m23_ff) ? m01_ff : m23_ff;
      fin_row = row_ff;
      if (raise_ff && row_ff.wmark < mfin) begin
         fin_row.wmark = mfin;
      end
      r_wr_data = fin_row;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pend_in = 1'b0;
      pidx_in = cnt_ff[AW-1:0];
      found_in = found_ff;
      free_in = free_ff;
      fidx_in = fidx_ff;
      eidx_in = eidx_ff;
      trk_in = trk_ff;
      ntrk_in = ntrk_ff;
      raise_in = raise_ff;
      rowwr_in = rowwr_ff;
      row_in = row_ff;
      m01_in = m01_ff;
      m23_in = m23_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in = status_ff;
      minh_in = minh_ff;
      otrk_in = otrk_ff;
      m_wr_en = 1'b0;
      m_wr_addr = cnt_ff[AW-1:0];
      m_wr_data = '0;
      r_wr_en = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            m_wr_en = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == LAST - CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               state_in = S_SCAN;
               cnt_in = '0;
               found_in = 1'b0;
               free_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (cnt_ff != LAST) begin
               pend_in = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
            if (pend_ff) begin
               if (m_rd_data.valid && m_rd_data.key == key_ff && !found_ff) begin
                  found_in = 1'b1;
                  fidx_in = pidx_ff;
                  trk_in = m_rd_data.tracked;
               end
               if (!m_rd_data.valid && !free_ff) begin
                  free_in = 1'b1;
                  eidx_in = pidx_ff;
               end
            end
            if (cnt_ff == LAST && !pend_ff) begin
               state_in = S_ROW;
               if (found_ff) begin
                  eidx_in = fidx_ff;
               end else begin
                  trk_in = '0;
               end
            end
         end
         S_ROW: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            state_in = S_MIN;
            row_in = r_rd_data;
            raise_in = 1'b0;
            rowwr_in = 1'b0;
            ntrk_in = trk_ff;
            unique case (cmd_ff)
               plwm_pkg::CMD_ADD: begin
                  ntrk_in = trk_ff | mask_ff;
                  rowwr_in = ok;
                  for (int t = 0; t < plwm_pkg::TYPES; t++) begin
                     if (mask_ff[t] && !trk_ff[t]) begin
                        row_in.height[t] = '0;
                        row_in.wmark = '0;
                     end
                  end
                  if (!found_ff) begin
                     row_in.wmark = '0;
                  end
               end
               plwm_pkg::CMD_DELETE: begin
                  ntrk_in = trk_ff & ~mask_ff;
                  rowwr_in = found_ff;
                  row_in.wmark = '0;
               end
               plwm_pkg::CMD_UPDATE: begin
                  if (found_ff && trk_ff[ht_ff] && r_rd_data.height[ht_ff] < nh_ff) begin
                     raise_in = 1'b1;
                     rowwr_in = 1'b1;
                     row_in.height[ht_ff] = nh_ff;
                  end
               end
               plwm_pkg::CMD_QUERY: begin
               end
               default: begin
               end
            endcase
         end
         S_MIN: begin
            state_in = S_FIN;
            m01_in = plwm_pkg::ALL_ONES;
            m23_in = plwm_pkg::ALL_ONES;
            if (ntrk_ff[0]) m01_in = row_ff.height[0];
            if (ntrk_ff[1] && row_ff.height[1] < m01_in) m01_in = row_ff.height[1];
            if (ntrk_ff[2]) m23_in = row_ff.height[2];
            if (ntrk_ff[3] && row_ff.height[3] < m23_in) m23_in = row_ff.height[3];
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               r_wr_en = rowwr_ff;
               m_wr_addr = eidx_ff;
               m_wr_data.key = key_ff;
               m_wr_data.tracked = ntrk_ff;
               m_wr_data.valid = (cmd_ff == plwm_pkg::CMD_ADD) || (ntrk_ff != '0);
               m_wr_en = ok && (cmd_ff == plwm_pkg::CMD_ADD
                                || cmd_ff == plwm_pkg::CMD_DELETE);
               otrk_in = ok ? ntrk_ff : '0;
               minh_in = (ok && cmd_ff == plwm_pkg::CMD_QUERY) ? row_ff.wmark : '0;
               if (ok) begin
                  status_in = plwm_pkg::ST_OK;
               end else if (cmd_ff == plwm_pkg::CMD_ADD) begin
                  status_in = plwm_pkg::ST_FULL;
               end else begin
                  status_in = plwm_pkg::ST_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      found_ff <= found_in;
      free_ff <= free_in;
      fidx_ff <= fidx_in;
      eidx_ff <= eidx_in;
      trk_ff <= trk_in;
      ntrk_ff <= ntrk_in;
      raise_ff <= raise_in;
      rowwr_ff <= rowwr_in;
      row_ff <= row_in;
      m01_ff <= m01_in;
      m23_ff <= m23_in;
      status_ff <= status_in;
      minh_ff <= minh_in;
      otrk_ff <= otrk_in;
      if (req_take) begin
         cmd_ff <= req_cmd;
         key_ff <= req_account_key;
         mask_ff <= req_type_mask;
         ht_ff <= req_height_sel;
         nh_ff <= req_new_height;
      end
   end

   `PLWM_ASSERT_NEXT(a_take_scan, clock, reset, req_take, state_ff == S_SCAN)
   `PLWM_ASSERT_IMPLIES(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_FIN))
   `PLWM_ASSERT_IMPLIES(a_no_meta_wr_scan, clock, reset, state_ff == S_SCAN, !m_wr_en)
   `PLWM_ASSERT_IMPLIES(a_status_code, clock, reset, rsp_valid_ff,
      status_ff <= plwm_pkg::ST_FULL)
endmodule

// ----- test/per_account_low_watermark_table_test.sv -----
// Self-checking testbench for the per-account low watermark table.
module per_account_low_watermark_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] key;
      logic [3:0]  mask;
      logic [1:0]  htype;
      logic [63:0] height;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] minh;
      logic [3:0]  tracked;
   } rsp_word_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [63:0] req_account_key = '0;
   logic [3:0]  req_type_mask = '0;
   logic [1:0]  req_height_sel = '0;
   logic [63:0] req_new_height = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_low_mark;
   logic [3:0]  rsp_tracked_types;

   per_account_low_watermark_table dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   req_word_type pending_cmds[$];
   rsp_word_type expected_rsps[$];
   int      mismatches = 0;
   int      cycle = 0;
   bit      calm = 0;

   // Mirror of the table contents.
   bit          acc_live[SLOTS];
   logic [63:0] acc_key[SLOTS];
   logic [3:0]  acc_types[SLOTS];
   logic [63:0] acc_height[SLOTS][plwm_pkg::TYPES];
   logic [63:0] acc_wmark[SLOTS];
   logic [63:0] key_pool[8];

   function automatic rsp_word_type apply_command(req_word_type w);
      rsp_word_type r;
      int s;
      int f;
      logic [63:0] m;
      r = '0;
      s = -1;
      f = -1;
      for (int i = 0; i < SLOTS; i++)
         if (acc_live[i] && acc_key[i] == w.key && s < 0) s = i;
      for (int i = 0; i < SLOTS; i++)
         if (!acc_live[i] && f < 0) f = i;
      case (w.cmd)
         plwm_pkg::CMD_ADD: begin
            if (s < 0 && f < 0) begin
               r.status = plwm_pkg::ST_FULL;
            end else begin
               if (s < 0) begin
                  s = f;
                  acc_live[s] = 1;
                  acc_key[s] = w.key;
                  acc_types[s] = '0;
                  acc_wmark[s] = '0;
               end
               for (int t = 0; t < plwm_pkg::TYPES; t++)
                  if (w.mask[t] && !acc_types[s][t]) begin
                     acc_types[s][t] = 1;
                     acc_height[s][t] = '0;
                     acc_wmark[s] = '0;
                  end
               r.tracked = acc_types[s];
            end
         end
         plwm_pkg::CMD_DELETE: begin
            if (s < 0) begin
               r.status = plwm_pkg::ST_NOT_FOUND;
            end else begin
               acc_types[s] &= ~w.mask;
               acc_wmark[s] = '0;
               if (acc_types[s] == '0) acc_live[s] = 0;
               r.tracked = acc_types[s];
            end
         end
         plwm_pkg::CMD_UPDATE: begin
            if (s < 0) begin
               r.status = plwm_pkg::ST_NOT_FOUND;
            end else begin
               if (acc_types[s][w.htype] && acc_height[s][w.htype] < w.height) begin
                  acc_height[s][w.htype] = w.height;
                  m = plwm_pkg::ALL_ONES;
                  for (int t = 0; t < plwm_pkg::TYPES; t++)
                     if (acc_types[s][t] && acc_height[s][t] < m) m = acc_height[s][t];
                  if (acc_wmark[s] < m) acc_wmark[s] = m;
               end
               r.tracked = acc_types[s];
            end
         end
         default: begin
            if (s < 0) begin
               r.status = plwm_pkg::ST_NOT_FOUND;
            end else begin
               r.minh = acc_wmark[s];
               r.tracked = acc_types[s];
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic queue_cmd(logic [1:0] c, logic [63:0] k, logic [3:0] m, logic [1:0] t,
                            logic [63:0] h);
      req_word_type w;
      w = '{cmd: c, key: k, mask: m, htype: t, height: h};
      pending_cmds.push_back(w);
   endtask

   function automatic logic [63:0] pick_height();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 40));
         1: return plwm_pkg::ALL_ONES - 64'($urandom_range(0, 3));
         default: return rand64();
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle);
      mismatches++;
   endtask

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = rand64();
      key_pool[0] = '0;
      key_pool[1] = plwm_pkg::ALL_ONES;
      // Directed part: empty add, full table, absent keys, extremes.
      queue_cmd(plwm_pkg::CMD_QUERY, 64'd5, 4'hF, 2'd3, plwm_pkg::ALL_ONES);
      queue_cmd(plwm_pkg::CMD_DELETE, 64'd5, 4'hF, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_UPDATE, 64'd5, 4'h0, 2'd1, 64'd9);
      queue_cmd(plwm_pkg::CMD_ADD, 64'd0, 4'h0, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_QUERY, 64'd0, 4'h0, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_ADD, plwm_pkg::ALL_ONES, 4'hF, 2'd3, plwm_pkg::ALL_ONES);
      queue_cmd(plwm_pkg::CMD_UPDATE, plwm_pkg::ALL_ONES, 4'h0, 2'd0, plwm_pkg::ALL_ONES);
      queue_cmd(plwm_pkg::CMD_UPDATE, plwm_pkg::ALL_ONES, 4'h0, 2'd1, plwm_pkg::ALL_ONES);
      queue_cmd(plwm_pkg::CMD_UPDATE, plwm_pkg::ALL_ONES, 4'h0, 2'd2, plwm_pkg::ALL_ONES);
      queue_cmd(plwm_pkg::CMD_UPDATE, plwm_pkg::ALL_ONES, 4'h0, 2'd3, plwm_pkg::ALL_ONES);
      queue_cmd(plwm_pkg::CMD_QUERY, plwm_pkg::ALL_ONES, 4'h0, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_UPDATE, plwm_pkg::ALL_ONES, 4'h0, 2'd3, 64'd7);
      queue_cmd(plwm_pkg::CMD_ADD, plwm_pkg::ALL_ONES, 4'h3, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_QUERY, plwm_pkg::ALL_ONES, 4'h0, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_DELETE, 64'd0, 4'h0, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_ADD, 64'd0, 4'h2, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_UPDATE, 64'd0, 4'h0, 2'd0, 64'd3);
      for (int i = 0; i < 15; i++)
         queue_cmd(plwm_pkg::CMD_ADD, 64'h100 + 64'(i), 4'h1, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_ADD, 64'h200, 4'hF, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_DELETE, plwm_pkg::ALL_ONES, 4'hF, 2'd0, '0);
      queue_cmd(plwm_pkg::CMD_ADD, 64'h200, 4'h5, 2'd0, '0);
      for (int i = 0; i < 15; i++)
         queue_cmd(plwm_pkg::CMD_DELETE, 64'h100 + 64'(i), 4'hF, 2'd0, '0);
      // Random part over a small key pool so accounts live long enough to climb.
      for (int n = 0; n < 800; n++) begin
         logic [63:0] k;
         int r;
         k = ($urandom_range(0, 19) == 0) ? rand64() : key_pool[3'($urandom_range(0, 7))];
         r = $urandom_range(0, 99);
         if (r < 15) queue_cmd(plwm_pkg::CMD_ADD, k, 4'($urandom_range(0, 15)),
                               2'($urandom_range(0, 3)), rand64());
         else if (r < 22) queue_cmd(plwm_pkg::CMD_DELETE, k, 4'($urandom_range(0, 15)),
                                    2'($urandom_range(0, 3)), rand64());
         else if (r < 75) queue_cmd(plwm_pkg::CMD_UPDATE, k, 4'($urandom_range(0, 15)),
                                    2'($urandom_range(0, 3)), pick_height());
         else queue_cmd(plwm_pkg::CMD_QUERY, k, 4'($urandom_range(0, 15)),
                        2'($urandom_range(0, 3)), rand64());
      end
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle == 11) reset <= 0;
      calm <= (cycle > 3000 && cycle < 9000);
      if (!reset && (!req_valid || !req_stall)) begin
         if (req_valid) expected_rsps.push_back(apply_command({req_cmd, req_account_key,
            req_type_mask, req_height_sel, req_new_height}));
         if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
            req_word_type w;
            w = pending_cmds.pop_front();
            req_valid <= 1;
            req_cmd <= w.cmd;
            req_account_key <= w.key;
            req_type_mask <= w.mask;
            req_height_sel <= w.htype;
            req_new_height <= w.height;
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_status), '0);
            end else begin
               rsp_word_type e;
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status)
                  report_mismatch("status", 64'(rsp_status), 64'(e.status));
               if (rsp_low_mark !== e.minh)
                  report_mismatch("low_mark", rsp_low_mark, e.minh);
               if (rsp_tracked_types !== e.tracked)
                  report_mismatch("tracked_types", 64'(rsp_tracked_types), 64'(e.tracked));
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 11);
      end
   end

   initial begin
      int settle;
      settle = 0;
      while (settle < 200 && cycle < LIMIT) begin
         @(posedge clock);
         if (!reset && pending_cmds.size() == 0 && !req_valid && expected_rsps.size() == 0)
            settle++;
         else
            settle = 0;
      end
      if (cycle >= LIMIT) begin
         $display("[FAIL] regression broken");
      end else if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
